@@ hdl/chm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package chm_pkg;

	// BUCKETS must be a power of two: the bucket is the low bits of the key,
	// which is the non-negative remainder for two's complement keys.
	localparam int BUCKETS    = 16;
	localparam int POOL_NODES = 64;

	localparam int FUNC_W = 2;
	localparam int KEY_W  = 32;
	localparam int NODE_W = $clog2(POOL_NODES + 1);
	localparam int IDX_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	typedef logic [FUNC_W-1:0]       func_t;
	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [NODE_W-1:0]       node_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [BKT_W-1:0]        bkt_t;

	// null node index
	localparam node_t NIL = node_t'(POOL_NODES);

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_SEARCH = 2'd1,
		FN_DELETE = 2'd2
	} fn_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_DISP,
		ST_RD,
		ST_CMP,
		ST_FREE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic  re;
		logic  we;
		bkt_t  addr;
		node_t wdata;
	} head_req_t;

	typedef struct packed {
		logic  re;
		logic  we;
		idx_t  addr;
		node_t wdata;
	} link_req_t;

	function automatic logic is_node(input node_t n);
		return n < NIL;
	endfunction

	function automatic idx_t node_idx(input node_t n);
		return n[IDX_W-1:0];
	endfunction

	// reset link of a pool node: the next node, the last one links to null
	function automatic node_t link_init(input idx_t a);
		return node_t'(a) + node_t'(1);
	endfunction

	function automatic bkt_t bucket_of(input key_t k);
		logic [KEY_W-1:0] m;
		m = $unsigned(k) & KEY_W'(BUCKETS - 1);
		return m[BKT_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/chm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface chm_req_if
	import chm_pkg::*;
();
	logic  valid;
	logic  ready;
	func_t func;
	key_t  key;

	modport source (output valid, func, key, input ready);
	modport sink   (input valid, func, key, output ready);
endinterface

interface chm_rsp_if
	import chm_pkg::*;
();
	logic valid;
	logic ready;
	logic hit;
	logic pool_full;

	modport source (output valid, hit, pool_full, input ready);
	modport sink   (input valid, hit, pool_full, output ready);
endinterface

`default_nettype wire

@@ hdl/chained_hash_multiset_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Hash multiset of signed 32-bit keys, separate chaining over a fixed node pool.
// req channel: one beat per operation (func: insert, search, delete; key).
// rsp channel: exactly one beat per request (hit, pool_full), in request order.
// One request is worked on at a time; the work per operation:
//   insert (or unused func code): no chain walk, straight to the result.
//   search: walks the chain up to the first match or to its end, at most
//   POOL_NODES nodes.
//   delete: as search, plus a step to free a matched node.
// Each chain step is one read of the key and link RAMs and a compare in
// the next cycle, on the registered read data.
// The result sits in an output register; req.ready returns as soon as the
// result is handed there, so a new request is taken while rsp waits. If
// rsp is stalled when the next result is done, the block holds in its done
// state until the output register frees.
// Reset: all chains empty, free list holds every node in order from node 0.
// Valid bits in flops stand in for the cleared heads and links, so there
// is no clearing pass: the block takes requests right after reset.
// An insert with no free node is dropped and answers pool_full.
module chained_hash_multiset_core
	import chm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	chm_req_if.sink    req,
	chm_rsp_if.source  rsp
);

	state_t    state_q, state_nxt;

	// request being worked on
	func_t     func_q;
	key_t      key_q;
	bkt_t      bkt_q;

	// free list head and chain walk
	node_t     free_q;
	node_t     cur_q;
	node_t     prev_q;
	node_t     steps_q;

	logic      res_hit_q;
	logic      res_full_q;

	logic      out_vld_q;
	logic      out_hit_q;
	logic      out_full_q;

	head_req_t head_req;
	link_req_t link_req;
	node_t     head_rd;
	node_t     link_rd;

	logic      key_we;
	logic      key_re;
	key_t      key_rd;

	logic      walk_ok;
	logic      key_match;
	logic      out_free;
	node_t     link_nxt;

	chm_head_mem u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (head_req),
		.rdata  (head_rd)
	);

	chm_link_mem u_link (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (link_req),
		.rdata  (link_rd)
	);

	// node keys: written only by insert, read only for nodes on a chain
	chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_key (
		.clk   (clk),
		.we    (key_we),
		.waddr (node_idx(free_q)),
		.wdata (key_q),
		.re    (key_re),
		.raddr (node_idx(cur_q)),
		.rdata (key_rd)
	);

	assign walk_ok   = is_node(cur_q) && (steps_q < NIL);
	assign key_match = (key_rd == key_q);
	assign out_free  = !out_vld_q || rsp.ready;
	// a link that is no node ends the chain
	assign link_nxt  = is_node(link_rd) ? link_rd : NIL;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_nxt = ST_HEAD;
				end
			end
			ST_HEAD: begin
				state_nxt = ST_DISP;
			end
			ST_DISP: begin
				if (func_q == FN_SEARCH || func_q == FN_DELETE) begin
					state_nxt = ST_RD;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_RD: begin
				state_nxt = walk_ok ? ST_CMP : ST_DONE;
			end
			ST_CMP: begin
				if (!key_match) begin
					state_nxt = ST_RD;
				end else if (func_q == FN_DELETE) begin
					state_nxt = ST_FREE;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_FREE: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// memory accesses and handshake
	always_comb begin
		head_req  = '0;
		link_req  = '0;
		key_we    = 1'b0;
		key_re    = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_HEAD: begin
				// bucket head and the link out of the free head
				head_req.re   = 1'b1;
				head_req.addr = bkt_q;
				link_req.re   = 1'b1;
				link_req.addr = node_idx(free_q);
			end
			ST_DISP: begin
				if (func_q == FN_INSERT && is_node(free_q)) begin
					key_we         = 1'b1;
					head_req.we    = 1'b1;
					head_req.addr  = bkt_q;
					head_req.wdata = free_q;
					link_req.we    = 1'b1;
					link_req.addr  = node_idx(free_q);
					link_req.wdata = head_rd;
				end
			end
			ST_RD: begin
				if (walk_ok) begin
					key_re        = 1'b1;
					link_req.re   = 1'b1;
					link_req.addr = node_idx(cur_q);
				end
			end
			ST_CMP: begin
				// unlink the first match
				if (key_match && func_q == FN_DELETE) begin
					if (is_node(prev_q)) begin
						link_req.we    = 1'b1;
						link_req.addr  = node_idx(prev_q);
						link_req.wdata = link_nxt;
					end else begin
						head_req.we    = 1'b1;
						head_req.addr  = bkt_q;
						head_req.wdata = link_nxt;
					end
				end
			end
			ST_FREE: begin
				// push the removed node on the free list
				link_req.we    = 1'b1;
				link_req.addr  = node_idx(cur_q);
				link_req.wdata = free_q;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			free_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DISP && func_q == FN_INSERT && is_node(free_q)) begin
				free_q <= link_nxt;
			end else if (state_q == ST_FREE) begin
				free_q <= cur_q;
			end
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					func_q <= req.func;
					key_q  <= req.key;
					bkt_q  <= bucket_of(req.key);
				end
			end
			ST_DISP: begin
				cur_q   <= head_rd;
				prev_q  <= NIL;
				steps_q <= '0;
				if (func_q == FN_INSERT) begin
					res_hit_q  <= is_node(free_q);
					res_full_q <= !is_node(free_q);
				end else begin
					res_hit_q  <= 1'b0;
					res_full_q <= 1'b0;
				end
			end
			ST_CMP: begin
				if (key_match) begin
					res_hit_q <= 1'b1;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= link_rd;
					steps_q <= steps_q + node_t'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_hit_q  <= res_hit_q;
					out_full_q <= res_full_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.hit       = out_hit_q;
	assign rsp.pool_full = out_full_q;

endmodule

`default_nettype wire

@@ hdl/chm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/chm_head_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// bucket heads: RAM plus a valid bit per bucket, unwritten buckets read null
module chm_head_mem
	import chm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  head_req_t req,
	output node_t     rdata
);

	logic [BUCKETS-1:0] vld_q;
	logic               rd_vld_s1;
	node_t              ram_q;

	chm_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_ram (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.addr),
		.wdata (req.wdata),
		.re    (req.re),
		.raddr (req.addr),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				rd_vld_s1 <= vld_q[req.addr];
			end
		end
	end

	assign rdata = rd_vld_s1 ? ram_q : NIL;

endmodule

`default_nettype wire

@@ hdl/chm_link_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// node links: RAM plus a valid bit per node, unwritten nodes read their reset link
module chm_link_mem
	import chm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  link_req_t req,
	output node_t     rdata
);

	logic [POOL_NODES-1:0] vld_q;
	logic                  rd_vld_s1;
	idx_t                  rd_addr_s1;
	node_t                 ram_q;

	chm_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_ram (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.addr),
		.wdata (req.wdata),
		.re    (req.re),
		.raddr (req.addr),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				rd_vld_s1 <= vld_q[req.addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_addr_s1 <= req.addr;
		end
	end

	assign rdata = rd_vld_s1 ? ram_q : link_init(rd_addr_s1);

endmodule

`default_nettype wire
